// ----- sv/swm_pkg.sv -----
`default_nettype none

package swm_pkg;

    // default sizes
    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // window size register
    localparam int          CFG_W        = 7;
    localparam logic [6:0]  WINDOW_RESET = 7'd1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVICT,
        ST_POP,
        ST_PUSH
    } swm_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic take;
        logic evict;
        logic pop;
        logic push;
    } swm_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic pop_ok;
        logic out_free;
    } swm_status_t;

endpackage

`default_nettype wire

// ----- sv/swm_sample_if.sv -----
`default_nettype none

interface swm_sample_if #(
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

`default_nettype wire

// ----- sv/swm_result_if.sv -----
`default_nettype none

interface swm_result_if #(
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

`default_nettype wire

// ----- sv/swm_ctrl.sv -----
`default_nettype none

module swm_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  swm_pkg::swm_status_t status,
    output swm_pkg::swm_cmd_t    cmd
);
    import swm_pkg::*;

    swm_state_t state_reg;
    swm_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT:
            begin
                cmd.evict  = 1'b1;
                state_next = ST_POP;
            end
            ST_POP:
            begin
                // one smaller tail candidate dropped per cycle
                if (status.pop_ok)
                begin
                    cmd.pop = 1'b1;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/swm_datapath.sv -----
`default_nettype none

module swm_datapath #(
    parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_wr_en,
    input  wire [swm_pkg::CFG_W-1:0]      cfg_wr_data,
    input  wire signed [SAMPLE_BITS-1:0]  in_sample,
    input  wire                           in_restart,
    input  wire                           out_ready,
    output logic                          out_valid,
    output logic signed [SAMPLE_BITS-1:0] out_data,
    input  swm_pkg::swm_cmd_t             cmd,
    output swm_pkg::swm_status_t          status
);
    import swm_pkg::*;

    localparam int IDX_W = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int WS_W  = CNT_W + CFG_W;

    // index wrap for sums below twice the depth
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] r;
        begin
            r = v;
            if (v >= SUM_W'(MAX_WINDOW))
            begin
                r = v - SUM_W'(MAX_WINDOW);
            end
            return r[IDX_W-1:0];
        end
    endfunction

    function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] v);
        begin
            return (v == IDX_W'(MAX_WINDOW - 1)) ? '0 : v + IDX_W'(1);
        end
    endfunction

    // stores
    logic signed [SAMPLE_BITS-1:0] cq_mem [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] rs_mem [MAX_WINDOW];

    logic [CFG_W-1:0]              window_size_reg;
    logic [IDX_W-1:0]              head_reg, head_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [IDX_W-1:0]              hp_reg, hp_next;
    logic [CNT_W-1:0]              seen_reg, seen_next;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] rd_head_reg;
    logic signed [SAMPLE_BITS-1:0] rd_tail_reg;
    logic signed [SAMPLE_BITS-1:0] rd_leave_reg;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;

    logic [WS_W-1:0]  ws_wide;
    logic [CNT_W-1:0] k_eff;
    logic             clear;
    logic             full_window;
    logic [IDX_W-1:0] leave_addr;
    logic [IDX_W-1:0] tail_addr;
    logic [IDX_W-1:0] wr_addr;

    // effective window length, clamped to 1..MAX_WINDOW
    assign ws_wide = WS_W'(window_size_reg);
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            k_eff = CNT_W'(1);
        end
        else if (ws_wide > WS_W'(MAX_WINDOW))
        begin
            k_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            k_eff = ws_wide[CNT_W-1:0];
        end
    end

    assign clear       = cfg_wr_en || (cmd.take && in_restart);
    assign full_window = (seen_reg >= k_eff);

    // queue and history pointer update
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        hp_next    = hp_reg;
        seen_next  = seen_reg;
        if (clear)
        begin
            head_next  = '0;
            count_next = '0;
            hp_next    = '0;
            seen_next  = '0;
        end
        else if (cmd.evict)
        begin
            // head leaves with the oldest sample
            if (full_window && count_reg != '0 && rd_head_reg == rd_leave_reg)
            begin
                head_next  = inc_idx(head_reg);
                count_next = count_reg - CNT_W'(1);
            end
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
            hp_next    = inc_idx(hp_reg);
            if (seen_reg < k_eff)
            begin
                seen_next = seen_reg + CNT_W'(1);
            end
        end
    end

    // store addresses
    assign leave_addr = wrap_idx(SUM_W'(hp_next) + SUM_W'(MAX_WINDOW) - SUM_W'(k_eff));
    assign tail_addr  = (count_next == '0) ? head_next
                      : wrap_idx(SUM_W'(head_next) + SUM_W'(count_next) - SUM_W'(1));
    assign wr_addr    = wrap_idx(SUM_W'(head_reg) + SUM_W'(count_reg));

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_RESET;
            head_reg        <= '0;
            count_reg       <= '0;
            hp_reg          <= '0;
            seen_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                window_size_reg <= cfg_wr_data;
            end
            head_reg      <= head_next;
            count_reg     <= count_next;
            hp_reg        <= hp_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output beat handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.push && seen_next >= k_eff)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            x_reg <= in_sample;
        end
        if (cmd.push && seen_next >= k_eff)
        begin
            // an empty queue before the append means the new sample is the head
            out_data_reg <= (count_reg == '0) ? x_reg : rd_head_reg;
        end
    end

    // candidate queue: one write, head and tail reads
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            cq_mem[wr_addr] <= x_reg;
        end
        rd_head_reg <= cq_mem[head_next];
        rd_tail_reg <= cq_mem[tail_addr];
    end

    // recent sample line store
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            rs_mem[hp_reg] <= x_reg;
        end
        rd_leave_reg <= rs_mem[leave_addr];
    end

    assign status.pop_ok   = (count_reg != '0) && (rd_tail_reg < x_reg);
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

`default_nettype wire

// ----- sv/sliding_window_maximum.sv -----
// sequence: take in idle, evict the head, drop smaller tail candidates, then append once
//   the output is free; no new sample is taken before the append; each sample is dropped
//   from the queue tail at most once, one drop per cycle through the queue ram
// reset: rst_n is asynchronous; it empties the window and sets window_size to 1
// the queue and line store rams are not cleared; write pointers make stale entries unread
`default_nettype none

module sliding_window_maximum #(
    parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      cfg_wr_en,
    input  wire [swm_pkg::CFG_W-1:0] cfg_wr_data,
    swm_sample_if.sink               samples,
    swm_result_if.source             results
);
    import swm_pkg::*;

    swm_cmd_t    cmd;
    swm_status_t status;
    logic        in_ready;
    logic        out_valid;
    logic signed [SAMPLE_BITS-1:0] out_data;

    // sequencer
    swm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // queue, line store and output register
    swm_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_sample   (samples.sample),
        .in_restart  (samples.restart),
        .out_ready   (results.ready),
        .out_valid   (out_valid),
        .out_data    (out_data),
        .cmd         (cmd),
        .status      (status)
    );

    assign samples.ready      = in_ready;
    assign results.valid      = out_valid;
    assign results.window_max = out_data;

`ifndef SYNTH
    // at most one command per cycle
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.take, cmd.evict, cmd.pop, cmd.push}))
        else $error("more than one datapath command");

    // an accepted beat always starts the eviction step
    a_take_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> cmd.evict)
        else $error("accepted beat not followed by eviction");

    // a new result only comes from an append
    a_out_from_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(cmd.push))
        else $error("result raised without append");

    // append never overwrites a waiting result
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!results.valid || results.ready))
        else $error("append while result stalled");
`endif

endmodule

`default_nettype wire
